// ===== hdl/dpl_pkg.sv =====
// shared types, codes and constants of the dirty page range logger
`default_nettype none
package dpl_pkg;

  localparam int AREA_COUNT_DEF     = 8;
  localparam int PAGES_PER_AREA_DEF = 4096;
  localparam int PAGE_BITS          = 40;

  localparam int PAGE_W   = 40;
  localparam int FUNC_W   = 3;
  localparam int AREA_W   = 3;
  localparam int PAGES_W  = 13;
  localparam int SLOT_W   = 12;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 13;
  localparam int ACTIVE_W = 4;

  localparam logic [PAGE_W-1:0] PAGE_MASK = (PAGE_BITS >= PAGE_W) ? {PAGE_W{1'b1}} :
                                            PAGE_W'((64'd1 << PAGE_BITS) - 64'd1);

  // item functions
  localparam logic [FUNC_W-1:0] FN_SET_AREA    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RECORD      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_READ_COUNTS = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FLUSH       = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ_ENTRY  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR_BIT   = 3'd5;
  // unassigned function codes
  localparam logic [FUNC_W-1:0] FN_RSVD_A      = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD_B      = 3'd7;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK_NEW   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_AREA  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIRTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [PAGE_W-1:0]  page_number;
    logic [AREA_W-1:0]  area_select;
    logic [PAGES_W-1:0] area_pages;
    logic [SLOT_W-1:0]  list_slot;
    logic               slot_logging;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [AREA_W-1:0]   area_index;
    logic [COUNT_W-1:0]  entry_count;
    logic [PAGE_W-1:0]   page_out;
    logic                last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ADDR,
    S_BIT,
    S_SWEEP,
    S_DRAIN,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/dpl_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module dpl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/dpl_area_match.sv =====
// parallel area range compare with lowest-index priority
`default_nettype none
module dpl_area_match import dpl_pkg::*; #(
  parameter int AREA_COUNT = AREA_COUNT_DEF,
  parameter int CW         = 13
) (
  input  wire logic [PAGE_W-1:0]   page,
  input  wire logic [PAGE_W-1:0]   base [AREA_COUNT],
  input  wire logic [CW-1:0]       size [AREA_COUNT],
  input  wire logic [ACTIVE_W-1:0] active_n,
  output logic                     hit,
  output logic [AREA_W-1:0]        area
);
  logic [AREA_COUNT-1:0] hit_vec;

  always_comb begin
    for (int i = 0; i < AREA_COUNT; i++) begin
      hit_vec[i] = (i < 32'(active_n)) && (page >= base[i]) &&
                   ({1'b0, page} < ({1'b0, base[i]} + (PAGE_W+1)'(size[i])));
    end
    area = '0;
    for (int i = AREA_COUNT - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        area = AREA_W'(i);
      end
    end
    hit = |hit_vec;
  end
endmodule
`default_nettype wire

// ===== hdl/dirty_page_range_logger.sv =====
// top level: dirty page range logger with area table, dirty bit ram and page list ram
//
// Tracks guest page writes in up to AREA_COUNT areas of up to PAGES_PER_AREA pages. After
// reset the block sweeps the dirty bit ram to zero, one entry per cycle; no transaction is
// accepted during the sweep, configuration writes are. One item is worked at a time. A
// record write or a dirty bit clear goes from acceptance to result through decode and area
// compare, ram address, ram read data and read-modify-write; a list entry read takes the
// same steps. Flush and no-area items, and items ignored at decode, give their result
// straight from decode. Set area clears the area's dirty bits through the dirty ram write
// port. Read and clear counts gives one result per active area. The next item is taken in
// the cycle after the last result transaction of the current one completes; the single
// write port of the dirty ram and the registered read of both rams shape these steps.
`default_nettype none
module dirty_page_range_logger import dpl_pkg::*; #(
  parameter int AREA_COUNT     = AREA_COUNT_DEF,
  parameter int PAGES_PER_AREA = PAGES_PER_AREA_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [ACTIVE_W-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_item_t                out_data
);
  localparam int CW    = $clog2(PAGES_PER_AREA + 1);
  localparam int OW    = $clog2(PAGES_PER_AREA);
  localparam int DEPTH = AREA_COUNT * PAGES_PER_AREA;
  localparam int AW    = $clog2(DEPTH);
  localparam int AIW   = (AREA_COUNT > 1) ? $clog2(AREA_COUNT) : 1;

  state_t              state_r, state_nxt;
  in_item_t            req_r;
  logic [AREA_W-1:0]   cur_r, cur_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]       clr_end_r, clr_end_nxt;
  out_item_t           out_r, out_nxt;
  logic [ACTIVE_W-1:0] active_r;

  // area table, one entry per area
  logic [PAGE_W-1:0] base_r [AREA_COUNT];
  logic [CW-1:0]     size_r [AREA_COUNT];
  logic [CW-1:0]     cnt_r  [AREA_COUNT];

  logic tbl_set, cnt_inc, cnt_clr_one, cnt_clr_act;

  logic                dirty_we, dirty_wdata, dirty_rdata;
  logic [AW-1:0]       dirty_waddr, dirty_raddr;
  logic                list_we;
  logic [AW-1:0]       list_waddr, list_raddr;
  logic [PAGE_W-1:0]   list_rdata;

  logic [PAGE_W-1:0]   page_m;
  logic [ACTIVE_W-1:0] active_n;
  logic                m_hit;
  logic [AREA_W-1:0]   m_area;
  logic [AIW-1:0]      cur_idx;
  logic                cur_ok;
  logic [PAGE_W-1:0]   cur_base;
  logic [CW-1:0]       cur_size, cur_cnt, size_sat;
  logic [AW-1:0]       area_addr;
  logic [OW-1:0]       offset;

  function automatic out_item_t mk_out(logic [STATUS_W-1:0] st, logic [AREA_W-1:0] ai,
                                       logic [COUNT_W-1:0] cnt, logic [PAGE_W-1:0] pg,
                                       logic lst);
    out_item_t o;
    o.status      = st;
    o.area_index  = ai;
    o.entry_count = cnt;
    o.page_out    = pg;
    o.last        = lst;
    return o;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  assign page_m   = req_r.page_number & PAGE_MASK;
  assign active_n = (32'(active_r) > AREA_COUNT) ? ACTIVE_W'(AREA_COUNT) : active_r;
  assign cur_idx  = cur_r[AIW-1:0];
  assign cur_ok   = 32'(cur_r) < AREA_COUNT;
  assign cur_base = base_r[cur_idx];
  assign cur_size = size_r[cur_idx];
  assign cur_cnt  = cnt_r[cur_idx];
  // first ram entry of the current area
  assign area_addr = AW'(32'(cur_r) * PAGES_PER_AREA);
  assign offset    = OW'(page_m - cur_base);
  assign size_sat  = (32'(req_r.area_pages) > PAGES_PER_AREA) ? CW'(PAGES_PER_AREA) :
                                                                CW'(req_r.area_pages);

  assign dirty_raddr = area_addr + AW'(offset);
  assign list_raddr  = area_addr + AW'(req_r.list_slot);
  assign list_waddr  = area_addr + AW'(cur_cnt);

  dpl_area_match #(
    .AREA_COUNT (AREA_COUNT),
    .CW         (CW)
  ) u_match (
    .page     (page_m),
    .base     (base_r),
    .size     (size_r),
    .active_n (active_n),
    .hit      (m_hit),
    .area     (m_area)
  );

  // one dirty bit per page of every area
  dpl_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_dirty_ram (
    .clk   (clk),
    .we    (dirty_we),
    .waddr (dirty_waddr),
    .wdata (dirty_wdata),
    .raddr (dirty_raddr),
    .rdata (dirty_rdata)
  );

  // per-area list of newly dirtied pages
  dpl_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (page_m),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  // next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    clr_addr_nxt = clr_addr_r;
    clr_end_nxt  = clr_end_r;
    out_nxt      = out_r;
    dirty_we     = 1'b0;
    dirty_waddr  = clr_addr_r;
    dirty_wdata  = 1'b0;
    list_we      = 1'b0;
    tbl_set      = 1'b0;
    cnt_inc      = 1'b0;
    cnt_clr_one  = 1'b0;
    cnt_clr_act  = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // post-reset sweep of the dirty ram
        dirty_we     = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == clr_end_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cur_nxt   = in_data.area_select;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (req_r.func)
          FN_SET_AREA: begin
            if (!cur_ok) begin
              out_nxt   = mk_out(ST_IGNORED, cur_r, '0, '0, 1'b1);
              state_nxt = S_OUT;
            end else begin
              tbl_set      = 1'b1;
              clr_addr_nxt = area_addr;
              clr_end_nxt  = area_addr + AW'(PAGES_PER_AREA - 1);
              state_nxt    = S_SWEEP;
            end
          end
          FN_RECORD: begin
            if (!req_r.slot_logging) begin
              out_nxt   = mk_out(ST_BAD_SLOT, '0, '0, page_m, 1'b1);
              state_nxt = S_OUT;
            end else if (!m_hit) begin
              out_nxt   = mk_out(ST_NO_AREA, '0, '0, page_m, 1'b1);
              state_nxt = S_OUT;
            end else begin
              cur_nxt   = m_area;
              state_nxt = S_ADDR;
            end
          end
          FN_CLEAR_BIT: begin
            if (!m_hit) begin
              out_nxt   = mk_out(ST_NO_AREA, '0, '0, page_m, 1'b1);
              state_nxt = S_OUT;
            end else begin
              cur_nxt   = m_area;
              state_nxt = S_ADDR;
            end
          end
          FN_READ_COUNTS: begin
            if (active_n == '0) begin
              out_nxt   = mk_out(ST_NO_AREA, '0, '0, '0, 1'b1);
              state_nxt = S_OUT;
            end else begin
              cur_nxt   = '0;
              state_nxt = S_DRAIN;
            end
          end
          FN_FLUSH: begin
            cnt_clr_act = 1'b1;
            out_nxt     = mk_out(ST_OK_NEW, '0, '0, '0, 1'b1);
            state_nxt   = S_OUT;
          end
          FN_READ_ENTRY: begin
            if (!cur_ok) begin
              out_nxt   = mk_out(ST_IGNORED, cur_r, '0, '0, 1'b1);
              state_nxt = S_OUT;
            end else if (32'(req_r.list_slot) >= 32'(cur_cnt)) begin
              out_nxt   = mk_out(ST_IGNORED, cur_r, COUNT_W'(cur_cnt), '0, 1'b1);
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_ADDR;
            end
          end
          default: begin
            out_nxt   = mk_out(ST_IGNORED, '0, '0, '0, 1'b1);
            state_nxt = S_OUT;
          end
        endcase
      end
      S_ADDR: begin
        // ram read issued on the current area and offset
        state_nxt = S_BIT;
      end
      S_BIT: begin
        state_nxt = S_OUT;
        case (req_r.func)
          FN_RECORD: begin
            if (dirty_rdata) begin
              out_nxt = mk_out(ST_DIRTY, cur_r, COUNT_W'(cur_cnt), page_m, 1'b1);
            end else begin
              dirty_we    = 1'b1;
              dirty_waddr = dirty_raddr;
              dirty_wdata = 1'b1;
              if (cur_cnt >= cur_size) begin
                out_nxt = mk_out(ST_FULL, cur_r, COUNT_W'(cur_cnt), page_m, 1'b1);
              end else begin
                list_we = 1'b1;
                cnt_inc = 1'b1;
                out_nxt = mk_out(ST_OK_NEW, cur_r, COUNT_W'(CW'(cur_cnt + 1'b1)),
                                 page_m, 1'b1);
              end
            end
          end
          FN_CLEAR_BIT: begin
            if (dirty_rdata) begin
              dirty_we    = 1'b1;
              dirty_waddr = dirty_raddr;
              out_nxt     = mk_out(ST_OK_NEW, cur_r, COUNT_W'(cur_cnt), page_m, 1'b1);
            end else begin
              out_nxt = mk_out(ST_IGNORED, cur_r, COUNT_W'(cur_cnt), page_m, 1'b1);
            end
          end
          FN_READ_ENTRY: begin
            out_nxt = mk_out(ST_OK_NEW, cur_r, COUNT_W'(cur_cnt), list_rdata, 1'b1);
          end
          default: begin
            out_nxt = mk_out(ST_IGNORED, '0, '0, '0, 1'b1);
          end
        endcase
      end
      S_SWEEP: begin
        // clear the dirty bits of a newly set area
        dirty_we     = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == clr_end_r) begin
          out_nxt   = mk_out(ST_OK_NEW, cur_r, '0, page_m, 1'b1);
          state_nxt = S_OUT;
        end
      end
      S_DRAIN: begin
        // report one area's count and clear it
        cnt_clr_one = 1'b1;
        out_nxt     = mk_out(ST_OK_NEW, cur_r, COUNT_W'(cur_cnt), '0,
                             (ACTIVE_W'(cur_r) + 1'b1) == active_n);
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (out_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt   = cur_r + 1'b1;
            state_nxt = S_DRAIN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      cur_r      <= '0;
      clr_addr_r <= '0;
      clr_end_r  <= AW'(DEPTH - 1);
      active_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      cur_r      <= cur_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_end_r  <= clr_end_nxt;
      if (cfg_valid) begin
        active_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  // area table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AREA_COUNT; i++) begin
        base_r[i] <= '0;
        size_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (tbl_set) begin
        base_r[cur_idx] <= page_m;
        size_r[cur_idx] <= size_sat;
        cnt_r[cur_idx]  <= '0;
      end
      if (cnt_inc) begin
        cnt_r[cur_idx] <= cur_cnt + 1'b1;
      end
      if (cnt_clr_one) begin
        cnt_r[cur_idx] <= '0;
      end
      if (cnt_clr_act) begin
        for (int i = 0; i < AREA_COUNT; i++) begin
          if (i < 32'(active_n)) begin
            cnt_r[i] <= '0;
          end
        end
      end
    end
  end

  // a list push never goes past the area size
  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    list_we |-> (cur_cnt < cur_size))
    else $error("list push beyond area size");

  // sweeps only ever clear dirty bits
  a_sweep_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (dirty_we && (state_r == S_CLEAR || state_r == S_SWEEP)) |-> !dirty_wdata)
    else $error("sweep writes a set dirty bit");

  // a final result transaction returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_ready && out_r.last) |=> (state_r == S_IDLE))
    else $error("block not idle after final result");

  // a new item is never accepted while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted with result pending");

endmodule
`default_nettype wire

// ===== tb/sv/tb_dirty_page_range_logger.sv =====
// self-checking testbench of the dirty page range logger
`default_nettype none
module tb_dirty_page_range_logger;
  import dpl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AREAS = AREA_COUNT_DEF;
  localparam int PAGES = PAGES_PER_AREA_DEF;
  localparam int MAX_SHOWN = 10;

  // shadow of the logger: area table, dirty bits, page lists and the queue of
  // result transactions that still have to come out of the block
  class page_log_scoreboard;
    logic [PAGE_W-1:0]  base [AREAS];
    logic [COUNT_W-1:0] size [AREAS];
    logic [COUNT_W-1:0] count [AREAS];
    bit                 dirty [AREAS*PAGES];
    logic [PAGE_W-1:0]  pages_logged [AREAS*PAGES];
    int unsigned        active;
    out_item_t          expected_results [$];
    int                 errors;

    function new();
      active = 0;
      errors = 0;
      for (int i = 0; i < AREAS; i++) begin
        base[i] = '0;
        size[i] = '0;
        count[i] = '0;
      end
      for (int j = 0; j < AREAS*PAGES; j++) begin
        dirty[j] = 1'b0;
        pages_logged[j] = '0;
      end
    endfunction

    function int areas_checked();
      return (active > AREAS) ? AREAS : int'(active);
    endfunction

    // lowest-index active area holding the page, -1 when none does
    function int match_area(logic [PAGE_W-1:0] p);
      for (int i = 0; i < areas_checked(); i++) begin
        if ({1'b0, p} >= {1'b0, base[i]} && {1'b0, p} < {1'b0, base[i]} + size[i])
          return i;
      end
      return -1;
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      logic [PAGE_W-1:0] p;
      int a;
      int n;
      int idx;
      p = it.page_number & PAGE_MASK;
      n = areas_checked();
      r = '0;
      r.last = 1'b1;
      case (it.func)
        FN_SET_AREA: begin
          base[it.area_select] = p;
          size[it.area_select] = (it.area_pages > PAGES) ? COUNT_W'(PAGES) : it.area_pages;
          count[it.area_select] = '0;
          for (int j = 0; j < PAGES; j++) dirty[it.area_select*PAGES + j] = 1'b0;
          r.status = ST_OK_NEW;
          r.area_index = it.area_select;
          r.page_out = p;
        end
        FN_RECORD: begin
          r.page_out = p;
          a = match_area(p);
          if (!it.slot_logging) begin
            r.status = ST_BAD_SLOT;
          end else if (a < 0) begin
            r.status = ST_NO_AREA;
          end else begin
            idx = a*PAGES + int'(p - base[a]);
            r.area_index = AREA_W'(a);
            if (dirty[idx]) begin
              r.status = ST_DIRTY;
            end else begin
              dirty[idx] = 1'b1;
              if (count[a] >= size[a]) begin
                r.status = ST_FULL;
              end else begin
                pages_logged[a*PAGES + count[a]] = p;
                count[a] = count[a] + 1'b1;
                r.status = ST_OK_NEW;
              end
            end
            r.entry_count = count[a];
          end
        end
        FN_READ_COUNTS: begin
          if (n == 0) begin
            r.status = ST_NO_AREA;
          end else begin
            for (int i = 0; i < n; i++) begin
              r.status = ST_OK_NEW;
              r.area_index = AREA_W'(i);
              r.entry_count = count[i];
              r.last = (i == n - 1);
              expected_results.push_back(r);
              count[i] = '0;
            end
            return;
          end
        end
        FN_FLUSH: begin
          for (int i = 0; i < n; i++) count[i] = '0;
          r.status = ST_OK_NEW;
        end
        FN_READ_ENTRY: begin
          r.area_index = it.area_select;
          r.entry_count = count[it.area_select];
          if (it.list_slot >= count[it.area_select]) begin
            r.status = ST_IGNORED;
          end else begin
            r.status = ST_OK_NEW;
            r.page_out = pages_logged[it.area_select*PAGES + it.list_slot];
          end
        end
        FN_CLEAR_BIT: begin
          r.page_out = p;
          a = match_area(p);
          if (a < 0) begin
            r.status = ST_NO_AREA;
          end else begin
            idx = a*PAGES + int'(p - base[a]);
            r.area_index = AREA_W'(a);
            r.entry_count = count[a];
            r.status = dirty[idx] ? ST_OK_NEW : ST_IGNORED;
            dirty[idx] = 1'b0;
          end
        end
        default: r.status = ST_IGNORED;
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) $display("unexpected result %p", got);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.area_index !== want.area_index ||
          got.entry_count !== want.entry_count || got.page_out !== want.page_out ||
          got.last !== want.last) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [ACTIVE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  in_item_t in_data = '0;
  logic out_ready = 1'b0;
  logic cfg_ready, in_ready, out_valid;
  out_item_t out_data;

  page_log_scoreboard log_sb = new();
  int burst_left = 0;

  dirty_page_range_logger dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // input and result monitors sample at the edge, before any update lands
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) log_sb.note_item(in_data);
    if (rst_n && out_valid && out_ready) log_sb.check_result(out_data);
  end

  // receiver: back-pressure style is picked anew at random, now and then
  int stall_mode = 0;
  int stall_cyc = 0;
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;                       // no stall at all
      1: out_ready <= $urandom_range(0, 1);       // heavy random stall
      2: out_ready <= (stall_cyc % 3 != 0);       // fixed periodic stall
      default: out_ready <= ($urandom_range(0, 6) != 0);
    endcase
  end

  // one input transaction; the sender runs in bursts with idle gaps between some bursts
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // drain all expected results, then give the block time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (log_sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_active(logic [ACTIVE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    log_sb.active = v;
  endtask

  function automatic in_item_t make_item(logic [FUNC_W-1:0] f, logic [PAGE_W-1:0] p,
                                         logic [AREA_W-1:0] sel, logic [PAGES_W-1:0] np,
                                         logic [SLOT_W-1:0] slot, logic lg);
    in_item_t it;
    it.func = f;
    it.page_number = p;
    it.area_select = sel;
    it.area_pages = np;
    it.list_slot = slot;
    it.slot_logging = lg;
    return it;
  endfunction

  // random item: mostly writes and bit clears aimed at defined areas
  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    int a;
    it = $bits(in_item_t)'({$urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    a = $urandom_range(0, AREAS - 1);
    if (pick < 64) begin
      it.func = (pick < 48) ? FN_RECORD : FN_CLEAR_BIT;
      it.slot_logging = ($urandom_range(0, 9) != 0);
      // near an area: inside it, or just past either end
      if ($urandom_range(0, 9) != 0)
        it.page_number = log_sb.base[a] + PAGE_W'($urandom_range(0, 3 + log_sb.size[a])) - 1;
    end else if (pick < 78) begin
      it.func = FN_READ_ENTRY;
      it.area_select = AREA_W'(a);
      if (log_sb.count[a] != 0 && $urandom_range(0, 3) != 0)
        it.list_slot = SLOT_W'($urandom_range(0, log_sb.count[a] - 1));
    end else if (pick < 86) begin
      it.func = FN_READ_COUNTS;
    end else if (pick < 91) begin
      it.func = FN_FLUSH;
    end else if (pick < 95) begin
      it.func = ($urandom_range(0, 1) != 0) ? FN_RSVD_A : FN_RSVD_B;
    end else begin
      // redefining an area is slow, keep these rare and mostly small
      it.func = FN_SET_AREA;
      if ($urandom_range(0, 2) != 0) it.area_pages = PAGES_W'($urandom_range(0, 12));
      if ($urandom_range(0, 3) == 0) it.page_number = {PAGE_W{1'b1}} - $urandom_range(0, 20);
    end
    return it;
  endfunction

  logic [ACTIVE_W-1:0] phase_active [6] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd8};
  localparam logic [PAGE_W-1:0] TOP_PAGE = {PAGE_W{1'b1}};

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_active(phase_active[0]);

    // directed: overlapping areas, area at the top of the page space, empty area
    send_item(make_item(FN_SET_AREA, 40'h100, 3'd0, 13'd4, '0, 1'b0));
    send_item(make_item(FN_SET_AREA, 40'h100, 3'd1, 13'd2, '0, 1'b0));
    send_item(make_item(FN_SET_AREA, TOP_PAGE - 15, 3'd7, 13'h1FFF, '0, 1'b1));
    send_item(make_item(FN_SET_AREA, 40'h0, 3'd2, 13'd0, '0, 1'b0));
    send_item(make_item(FN_RECORD, 40'h100, 3'd0, '0, '0, 1'b0));    // logging off
    send_item(make_item(FN_RECORD, 40'h100, 3'd0, '0, '0, 1'b1));    // new page
    send_item(make_item(FN_RECORD, 40'h100, 3'd0, '0, '0, 1'b1));    // already dirty
    for (int k = 1; k < 4; k++)
      send_item(make_item(FN_RECORD, 40'h100 + k, 3'd0, '0, '0, 1'b1));
    send_item(make_item(FN_CLEAR_BIT, 40'h103, 3'd0, '0, '0, 1'b0)); // was set
    send_item(make_item(FN_CLEAR_BIT, 40'h103, 3'd0, '0, '0, 1'b1)); // already clear
    send_item(make_item(FN_RECORD, 40'h103, 3'd0, '0, '0, 1'b1));    // list full
    send_item(make_item(FN_RECORD, TOP_PAGE, 3'd0, '0, '0, 1'b1));
    send_item(make_item(FN_RECORD, 40'h50, 3'd0, '0, '0, 1'b1));     // no area
    send_item(make_item(FN_CLEAR_BIT, 40'h50, 3'd0, '0, '0, 1'b1));
    send_item(make_item(FN_READ_ENTRY, '0, 3'd0, '0, 12'd3, 1'b0));
    send_item(make_item(FN_READ_ENTRY, '0, 3'd0, '0, 12'd4, 1'b0));
    send_item(make_item(FN_READ_ENTRY, '0, 3'd0, '0, 12'hFFF, 1'b1));
    send_item(make_item(FN_READ_ENTRY, '0, 3'd7, '0, 12'd0, 1'b0));
    send_item(make_item(FN_READ_COUNTS, TOP_PAGE, 3'd7, 13'h1FFF, 12'hFFF, 1'b1));
    send_item(make_item(FN_FLUSH, '0, '0, '0, '0, 1'b0));
    send_item(make_item(FN_RSVD_A, TOP_PAGE, '0, '0, '0, 1'b1));
    send_item(make_item(FN_RSVD_B, '0, 3'd7, '0, '0, 1'b0));

    // random phases, each under its own area count
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        wait_idle();
        write_active(phase_active[ph]);
      end
      repeat (56) send_item(random_item());
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (log_sb.errors == 0 && log_sb.expected_results.size() == 0) begin
      $display("PASS dirty_page_range_logger");
    end else begin
      $display("FAIL dirty_page_range_logger");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #20ms;
    $display("FAIL dirty_page_range_logger");
    $finish;
  end

endmodule
`default_nettype wire
